/* rtl/tsrr_pkg.sv */
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared types and constants for the trie shortest-root replacement block.
// ----------------------------------------------------------------------------
package tsrr_pkg;

    localparam int SYM_W   = 5;
    localparam int TDATA_W = 8;

    localparam logic [SYM_W-1:0] SPACE_CODE = 5'd26;

    localparam logic OP_DICT     = 1'b0;
    localparam logic OP_SENTENCE = 1'b1;

    typedef enum logic [1:0] {
        MODE_MATCH    = 2'd0,
        MODE_SUPPRESS = 2'd1,
        MODE_COPY     = 2'd2
    } mode_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_en;   // clearing pass: zero one table entry
        logic accept;     // input beat taken, launch table read
        logic commit;     // apply the item, write table / load output
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last; // clearing pass at the final entry
        logic produce;    // item under execution yields an output beat
        logic out_stall;  // output beat is due but the register holds an untaken beat
        logic full;       // sticky table-full flag
    } sts_t;

endpackage

/* rtl/tsrr_ctrl.sv */
// ----------------------------------------------------------------------------
// tsrr_ctrl
// Sequencer: clearing pass after reset, then accept / execute per item.
// ----------------------------------------------------------------------------
module tsrr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  tsrr_pkg::sts_t  sts,
    output tsrr_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.clear_en = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold while the result has nowhere to go
                if (!sts.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/tsrr_dpath.sv */
// ----------------------------------------------------------------------------
// tsrr_dpath
// Child table memory, insert and match cursors, and the output register.
// ----------------------------------------------------------------------------
module tsrr_dpath #(
    parameter int NODE_COUNT = 4096,
    parameter int ALPHABET   = 26
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsrr_pkg::cmd_t                cmd,
    output tsrr_pkg::sts_t                sts,
    input  logic [tsrr_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsrr_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int DEPTH  = NODE_COUNT * ALPHABET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ENT_W  = NODE_W + 1;   // {end_mark_of_child, child}
    localparam int SYM_W  = tsrr_pkg::SYM_W;

    logic [ENT_W-1:0]  table_mem [DEPTH];

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ENT_W-1:0]  rd_data_reg;
    logic              op_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              last_reg;

    logic [NODE_W-1:0] ins_cur_reg, ins_cur_next;
    logic              ins_drop_reg, ins_drop_next;
    logic [ADDR_W-1:0] edge_reg, edge_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [NODE_W-1:0] match_cur_reg, match_cur_next;
    tsrr_pkg::mode_t   mode_reg, mode_next;
    logic              full_reg, full_next;

    logic              m_valid_reg;
    logic [SYM_W-1:0]  m_sym_reg;
    logic              m_has_reg;
    logic              m_last_reg;
    logic              m_full_reg;

    // read address, formed from the incoming beat
    logic [SYM_W-1:0]  in_sym;
    logic              in_letter;
    logic [NODE_W-1:0] in_node;
    logic [ADDR_W-1:0] rd_addr;

    assign in_sym    = s_tdata[SYM_W-1:0];
    assign in_letter = (int'(in_sym) < ALPHABET) && (in_sym != tsrr_pkg::SPACE_CODE);
    assign in_node   = (s_tuser == tsrr_pkg::OP_DICT) ? ins_cur_reg : match_cur_reg;
    assign rd_addr   = in_letter ?
                       ADDR_W'(in_node) * ADDR_W'(ALPHABET) + ADDR_W'(in_sym) : '0;

    // execute-stage decode
    logic              ex_letter;
    logic [NODE_W-1:0] rd_child;
    logic              rd_end;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              emit;

    assign ex_letter = (int'(sym_reg) < ALPHABET) && (sym_reg != tsrr_pkg::SPACE_CODE);
    assign rd_child  = rd_data_reg[NODE_W-1:0];
    assign rd_end    = rd_data_reg[NODE_W];

    always_comb begin
        ins_cur_next   = ins_cur_reg;
        ins_drop_next  = ins_drop_reg;
        edge_next      = edge_reg;
        used_next      = used_reg;
        match_cur_next = match_cur_reg;
        mode_next      = mode_reg;
        full_next      = full_reg;
        wr_en          = 1'b0;
        wr_addr        = rd_addr_reg;
        wr_data        = '0;
        emit           = 1'b1;

        if (op_reg == tsrr_pkg::OP_DICT) begin
            emit = 1'b0;
            if (!ins_drop_reg && ex_letter) begin
                if (rd_child == '0) begin
                    if (used_reg < CNT_W'(NODE_COUNT)) begin
                        // new node; end mark goes in with it if the root ends here
                        wr_en        = 1'b1;
                        wr_data      = {last_reg, used_reg[NODE_W-1:0]};
                        used_next    = used_reg + 1'b1;
                        ins_cur_next = used_reg[NODE_W-1:0];
                        edge_next    = rd_addr_reg;
                    end else begin
                        ins_drop_next = 1'b1;
                        full_next     = 1'b1;
                    end
                end else begin
                    ins_cur_next = rd_child;
                    edge_next    = rd_addr_reg;
                    if (last_reg) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, rd_child};
                    end
                end
            end else if (last_reg && !ins_drop_reg && ins_cur_reg != '0) begin
                // root ended on a non-letter: mark via the edge that led here
                wr_en   = 1'b1;
                wr_addr = edge_reg;
                wr_data = {1'b1, ins_cur_reg};
            end
            if (last_reg) begin
                ins_cur_next  = '0;
                ins_drop_next = 1'b0;
            end
        end else begin
            if (sym_reg == tsrr_pkg::SPACE_CODE) begin
                match_cur_next = '0;
                mode_next      = tsrr_pkg::MODE_MATCH;
            end else begin
                case (mode_reg)
                    tsrr_pkg::MODE_SUPPRESS: begin
                        emit = 1'b0;
                    end
                    tsrr_pkg::MODE_MATCH: begin
                        if (!ex_letter || rd_child == '0) begin
                            mode_next = tsrr_pkg::MODE_COPY;
                        end else begin
                            match_cur_next = rd_child;
                            if (rd_end) begin
                                mode_next = tsrr_pkg::MODE_SUPPRESS;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (last_reg) begin
                match_cur_next = '0;
                mode_next      = tsrr_pkg::MODE_MATCH;
            end
        end
    end

    assign sts.produce    = (op_reg == tsrr_pkg::OP_SENTENCE) && (emit || last_reg);
    assign sts.out_stall  = sts.produce && m_valid_reg && !m_tready;
    assign sts.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign sts.full       = full_reg;

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            table_mem[clr_addr_reg] <= '0;
        end else if (cmd.commit && wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.accept) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // item and output payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_addr_reg <= rd_addr;
            op_reg      <= s_tuser;
            sym_reg     <= in_sym;
            last_reg    <= s_tlast;
        end
        if (cmd.commit && sts.produce) begin
            m_sym_reg  <= emit ? sym_reg : '0;
            m_has_reg  <= emit;
            m_last_reg <= last_reg;
            m_full_reg <= full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            ins_cur_reg   <= '0;
            ins_drop_reg  <= 1'b0;
            edge_reg      <= '0;
            used_reg      <= CNT_W'(1);
            match_cur_reg <= '0;
            mode_reg      <= tsrr_pkg::MODE_MATCH;
            full_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.clear_en && !sts.clear_last) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.commit) begin
                ins_cur_reg   <= ins_cur_next;
                ins_drop_reg  <= ins_drop_next;
                edge_reg      <= edge_next;
                used_reg      <= used_next;
                match_cur_reg <= match_cur_next;
                mode_reg      <= mode_next;
                full_reg      <= full_next;
            end
            if (cmd.commit && sts.produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(tsrr_pkg::TDATA_W - SYM_W - 1){1'b0}}, m_full_reg, m_sym_reg};
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/trie_shortest_root_replace.sv */
// ----------------------------------------------------------------------------
// trie_shortest_root_replace
// Replaces each sentence word by the shortest dictionary root it starts with.
// ----------------------------------------------------------------------------
// Input stream (s_*): one symbol per beat. s_tuser = 0 adds a letter to the
// current dictionary root, s_tlast ends the root. s_tuser = 1 is a sentence
// symbol (letter or space), s_tlast ends the sentence.
// Output stream (m_*): echoed sentence symbols; letters past a matched root
// are dropped up to the next space. m_tuser = 0 with m_tlast is a bare end
// marker. m_tdata[5] is the sticky dict_full flag. Dictionary beats give no
// output.
// An item is accepted in idle, which launches the child-table read, and is
// applied in execute (table write or cursor update), which also loads the
// output register; s_tready is low until it is applied. A full output
// register whose beat is not taken holds an item that yields a beat in
// execute; s_tready stays low meanwhile. After reset the child table is
// zeroed one entry per cycle, all NODE_COUNT * ALPHABET entries (106496 by
// default); s_tready is low then.
// ----------------------------------------------------------------------------
module trie_shortest_root_replace #(
    parameter int NODE_COUNT = 4096,
    parameter int ALPHABET   = 26
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tsrr_pkg::TDATA_W-1:0]  s_tdata,  // [4:0] symbol, [7:5] zero
    input  logic                          s_tuser,  // [0] opcode
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsrr_pkg::TDATA_W-1:0]  m_tdata,  // [4:0] out_symbol, [5] dict_full
    output logic                          m_tuser,  // [0] has_symbol
    output logic                          m_tlast
);

    tsrr_pkg::cmd_t cmd;
    tsrr_pkg::sts_t sts;

    tsrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsrr_dpath #(
        .NODE_COUNT (NODE_COUNT),
        .ALPHABET   (ALPHABET)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // no beat is taken while the table is being cleared
    a_no_accept_in_clear: assert property (
        @(posedge aclk) disable iff (!aresetn) cmd.clear_en |-> !s_tready
    ) else $error("input accepted during clearing pass");

    // an output beat is only loaded into a free or draining register
    a_no_overwrite: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (cmd.commit && sts.produce) |-> (!m_tvalid || m_tready)
    ) else $error("output register overwritten");

    // table-full flag is sticky until reset
    a_full_sticky: assert property (
        @(posedge aclk) disable iff (!aresetn) sts.full |=> sts.full
    ) else $error("dict_full cleared without reset");

endmodule

/* tb/sv/trie_shortest_root_replace_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trie_shortest_root_replace_tb
// Self-checking bench for the shortest-root replacement block. Dictionary
// roots and sentences are streamed in with random gaps on both sides. A
// local trie model predicts every output beat, and each output beat is
// checked field by field in order.
// ----------------------------------------------------------------------------
module trie_shortest_root_replace_tb;

    localparam int SYM_W          = tsrr_pkg::SYM_W;
    localparam int TDATA_W        = tsrr_pkg::TDATA_W;
    localparam int NODES          = 4096;
    localparam int ALPHA          = 26;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 400000;   // clearing pass alone zeroes 106496 entries

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             has;
        logic             last;
        logic             full;
    } out_beat_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // trie model
    bit   [11:0]         trie_child [0:NODES*ALPHA-1];
    bit                  root_end   [0:NODES-1];
    int                  nodes_used = 1;
    int                  ins_node   = 0;
    bit                  ins_drop   = 1'b0;
    int                  walk_node  = 0;
    tsrr_pkg::mode_t     walk_mode  = tsrr_pkg::MODE_MATCH;
    bit                  table_full = 1'b0;
    out_beat_t           echo_q[$];

    // roots already sent, reused to build matching sentence words
    logic [SYM_W-1:0]    root_sym [0:511][0:7];
    int                  root_len [0:511];
    int                  root_cnt = 0;

    int                  mismatch_cnt = 0;
    int                  items_sent   = 0;
    int                  stall_cycles = 0;
    int                  ready_hold   = 0;
    bit                  no_idle      = 1'b0;
    out_beat_t           want;

    trie_shortest_root_replace uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SYM_W-1:0] rand_letter();
        // mostly a few letters so that words share prefixes with roots
        if ($urandom_range(0, 9) < 8)
            return SYM_W'($urandom_range(0, 5));
        return SYM_W'($urandom_range(0, ALPHA - 1));
    endfunction

    task automatic model_item(input logic op, input logic [SYM_W-1:0] sym, input logic last);
        int          eidx;
        logic [11:0] nxt;
        bit          emit;
        out_beat_t   beat;
        if (op == tsrr_pkg::OP_DICT) begin
            if (!ins_drop && sym < ALPHA) begin
                eidx = ins_node * ALPHA + sym;
                nxt  = trie_child[eidx];
                if (nxt == 0) begin
                    if (nodes_used < NODES) begin
                        nxt = 12'(nodes_used);
                        trie_child[eidx] = nxt;
                        nodes_used++;
                    end else begin
                        ins_drop   = 1'b1;
                        table_full = 1'b1;
                    end
                end
                if (!ins_drop)
                    ins_node = nxt;
            end
            if (last) begin
                if (!ins_drop)
                    root_end[ins_node] = 1'b1;
                ins_node = 0;
                ins_drop = 1'b0;
            end
            return;
        end
        emit = 1'b1;
        if (sym == tsrr_pkg::SPACE_CODE) begin
            walk_node = 0;
            walk_mode = tsrr_pkg::MODE_MATCH;
        end else if (walk_mode == tsrr_pkg::MODE_SUPPRESS) begin
            emit = 1'b0;
        end else if (walk_mode == tsrr_pkg::MODE_MATCH) begin
            nxt = '0;
            if (sym < ALPHA)
                nxt = trie_child[walk_node * ALPHA + sym];
            if (nxt == 0) begin
                walk_mode = tsrr_pkg::MODE_COPY;
            end else begin
                walk_node = nxt;
                if (root_end[nxt])
                    walk_mode = tsrr_pkg::MODE_SUPPRESS;
            end
        end
        if (last) begin
            walk_node = 0;
            walk_mode = tsrr_pkg::MODE_MATCH;
        end
        if (emit || last) begin
            beat.sym  = emit ? sym : '0;
            beat.has  = emit;
            beat.last = last;
            beat.full = table_full;
            echo_q = {echo_q, beat};
        end
    endtask

    // valid is only lowered when a gap follows, so back-to-back beats keep it high
    task automatic send_item(input logic op, input logic [SYM_W-1:0] sym, input logic last);
        int gap;
        if (items_sent % 50 == 0)
            no_idle = ($urandom_range(0, 4) == 0);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-SYM_W){1'b0}}, sym};
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_item(op, sym, last);
        items_sent++;
    endtask

    task automatic send_root();
        logic [SYM_W-1:0] letters [0:7];
        int               len;
        int               n;
        logic [SYM_W-1:0] sym;
        if ($urandom_range(0, 19) == 0) begin
            send_item(tsrr_pkg::OP_DICT, tsrr_pkg::SPACE_CODE, 1'b1);     // empty root
            return;
        end
        len = $urandom_range(1, 6);
        n   = 0;
        for (int i = 0; i < len; i++) begin
            sym = ($urandom_range(0, 29) == 0) ? tsrr_pkg::SPACE_CODE : rand_letter();
            if (sym != tsrr_pkg::SPACE_CODE) begin
                letters[n] = sym;
                n++;
            end
            send_item(tsrr_pkg::OP_DICT, sym, i == len - 1);
        end
        if (n > 0) begin
            int slot;
            slot = (root_cnt < 512) ? root_cnt : $urandom_range(0, 511);
            for (int i = 0; i < n; i++)
                root_sym[slot][i] = letters[i];
            root_len[slot] = n;
            if (root_cnt < 512)
                root_cnt++;
        end
    endtask

    task automatic send_word(input bit end_here);
        logic [SYM_W-1:0] word [0:15];
        int               wlen;
        int               kind;
        int               r;
        int               cut;
        wlen = 0;
        kind = $urandom_range(0, 3);
        if (kind < 2 && root_cnt > 0) begin
            r   = $urandom_range(0, root_cnt - 1);
            // whole root plus a tail, or a part of it plus diverging letters
            cut = (kind == 0) ? root_len[r] : $urandom_range(1, root_len[r]);
            for (int i = 0; i < cut; i++) begin
                word[wlen] = root_sym[r][i];
                wlen++;
            end
            repeat ($urandom_range(kind == 0 ? 0 : 1, 3)) begin
                word[wlen] = rand_letter();
                wlen++;
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                word[wlen] = rand_letter();
                wlen++;
            end
        end
        for (int i = 0; i < wlen; i++)
            send_item(tsrr_pkg::OP_SENTENCE, word[i], end_here && i == wlen - 1);
    endtask

    task automatic send_sentence();
        int  nwords;
        bit  space_end;
        nwords    = $urandom_range(1, 5);
        space_end = ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 9) == 0)
            send_item(tsrr_pkg::OP_SENTENCE, tsrr_pkg::SPACE_CODE, 1'b0);
        for (int w = 0; w < nwords; w++) begin
            send_word(!space_end && w == nwords - 1);
            if (w < nwords - 1) begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : 1)
                    send_item(tsrr_pkg::OP_SENTENCE, tsrr_pkg::SPACE_CODE, 1'b0);
            end
        end
        if (space_end)
            send_item(tsrr_pkg::OP_SENTENCE, tsrr_pkg::SPACE_CODE, 1'b1);
    endtask

    task automatic test_directed();
        // roots: "ba", "zy", empty, "de" with a space inside
        send_item(tsrr_pkg::OP_DICT, 5'd1, 1'b0);
        send_item(tsrr_pkg::OP_DICT, 5'd0, 1'b1);
        send_item(tsrr_pkg::OP_DICT, 5'd25, 1'b0);
        send_item(tsrr_pkg::OP_DICT, 5'd24, 1'b1);
        send_item(tsrr_pkg::OP_DICT, tsrr_pkg::SPACE_CODE, 1'b1);
        send_item(tsrr_pkg::OP_DICT, 5'd3, 1'b0);
        send_item(tsrr_pkg::OP_DICT, tsrr_pkg::SPACE_CODE, 1'b0);
        send_item(tsrr_pkg::OP_DICT, 5'd4, 1'b1);
        // "bad  zyx": suppression, double space, suppressed final letter -> end marker
        send_item(tsrr_pkg::OP_SENTENCE, 5'd1, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd0, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd3, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, tsrr_pkg::SPACE_CODE, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, tsrr_pkg::SPACE_CODE, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd25, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd24, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd23, 1'b1);
        // "cb ba ": copy mode, then match to a root, sentence ends on a space
        send_item(tsrr_pkg::OP_SENTENCE, 5'd2, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd1, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, tsrr_pkg::SPACE_CODE, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd1, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd0, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, tsrr_pkg::SPACE_CODE, 1'b1);
        // "de" ends exactly on a root with last; then a one-letter sentence
        send_item(tsrr_pkg::OP_SENTENCE, 5'd3, 1'b0);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd4, 1'b1);
        send_item(tsrr_pkg::OP_SENTENCE, 5'd0, 1'b1);
    endtask

    task automatic test_random();
        int stop_at;
        int r;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 25)
                send_root();
            else if (r < 93)
                send_sentence();
            else
                send_item(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 26)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            int g;
            g = pick_gap();
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= g - 1;
            end
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (echo_q.size() == 0) begin
                $display("%0t: output beat with nothing expected, expected none, got %0d/%0d/%0d",
                         $time, m_tdata[SYM_W-1:0], m_tuser, m_tlast);
                mismatch_cnt++;
            end else begin
                want = echo_q.pop_front();
                check_field("out_symbol", want.sym,  m_tdata[SYM_W-1:0]);
                check_field("has_symbol", want.has,  m_tuser);
                check_field("out_last",   want.last, m_tlast);
                check_field("dict_full",  want.full, m_tdata[SYM_W]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        s_tvalid <= 1'b0;
        while (echo_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tsrr_pkg.sv
rtl/tsrr_ctrl.sv
rtl/tsrr_dpath.sv
rtl/trie_shortest_root_replace.sv
tb/sv/trie_shortest_root_replace_tb.sv
